### rtl/glp_pkg.sv
// shared types and constants for the grid longest descent path block
`default_nettype none
package glp_pkg;

  // fixed field widths
  localparam int HEIGHT_W = 16;
  localparam int RESULT_W = 13;
  localparam int CFG_W    = 7;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // neighbour direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // per-node step: bit 2 clear while exploring, set while gathering lengths
  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_ROOT,
    S_HT,
    S_DIR,
    S_NB,
    S_WRITE,
    S_POP,
    S_NEXT
  } glp_state_t;

  // write strobes towards the cell store
  typedef struct packed {
    logic h_we;
    logic l_we;
  } glp_wr_t;

endpackage
`default_nettype wire

### rtl/glp_if.sv
// stream interfaces for grid cells in and path length out
`default_nettype none
interface glp_cell_if;
  import glp_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface glp_result_if;
  import glp_pkg::*;
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] longest_path;
  modport source (output valid, output longest_path, input ready);
  modport sink (input valid, input longest_path, output ready);
endinterface
`default_nettype wire

### rtl/glp_cell_store.sv
// height and memoised length memories, one shared read address
`default_nettype none
module glp_cell_store #(
  parameter int CELLS = 4096,
  parameter int AW    = 12,
  parameter int HB    = 16,
  parameter int LW    = 13
) (
  input  wire logic             clk,
  input  wire glp_pkg::glp_wr_t wr,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [HB-1:0]    h_wdata,
  input  wire logic [LW:0]      l_wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [HB-1:0]    h_rdata,
  output logic      [LW:0]      l_rdata
);
  import glp_pkg::*;

  logic [HB-1:0] h_mem [CELLS];
  logic [LW:0]   l_mem [CELLS];

  // height memory
  always_ff @(posedge clk) begin
    if (wr.h_we) begin
      h_mem[waddr] <= h_wdata;
    end
    h_rdata <= h_mem[raddr];
  end

  // length memory, top bit is the known mark
  always_ff @(posedge clk) begin
    if (wr.l_we) begin
      l_mem[waddr] <= l_wdata;
    end
    l_rdata <= l_mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/glp_walk_stack.sv
// depth-first walk stack memory
`default_nettype none
module glp_walk_stack #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int W     = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  import glp_pkg::*;

  logic [W-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/grid_longest_descent_path.sv
// Load: one cell per cycle into the height memory, the last one held while a result is unread;
// a cell's known mark is cleared as it loads. Walk after the last cell: a known cell passes S_CHECK,
// S_ROOT, S_NEXT; else a node takes S_HT, then S_DIR/S_NB per direction to explore and to gather
// lengths, then S_WRITE, via the one read port. One result per grid; no cells taken during the walk.
// Reset: synchronous; size registers go to 64 x 64, load position and stack empty, no clearing pass.
`default_nettype none
module grid_longest_descent_path #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  glp_cell_if.sink                        cells,
  glp_result_if.source                    result,
  input  wire logic                       wr_en,
  input  wire logic                       wr_index,
  input  wire logic [glp_pkg::CFG_W-1:0]  wr_data
);
  import glp_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNW   = $clog2(CELLS + 1);
  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSZ   = $clog2(MAX_ROWS + 1);
  localparam int CSZ   = $clog2(MAX_COLS + 1);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int SW    = AW + RB + CB + 3;

  glp_state_t state, state_next;

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [RSZ-1:0]   rows_eff;
  logic [CSZ-1:0]   cols_eff;
  logic [CNW-1:0]   total;

  logic [CNW-1:0]   pos;
  logic [CNW-1:0]   pos_inc;
  logic             last_cell;
  logic             accept;

  logic [CNW-1:0]   s_cnt;
  logic [RB-1:0]    sr;
  logic [CB-1:0]    sc;
  logic [AW-1:0]    top_t;
  logic [RB-1:0]    top_r;
  logic [CB-1:0]    top_c;
  logic [2:0]       step;
  logic [HEIGHT_BITS-1:0] ht;
  logic [LW-1:0]    acc;
  logic [CNW-1:0]   sp;
  logic [LW-1:0]    best;

  logic [AW-1:0]    nb_t;
  logic [RB-1:0]    nb_r;
  logic [CB-1:0]    nb_c;
  logic [AW-1:0]    cand_t;
  logic [RB-1:0]    cand_r;
  logic [CB-1:0]    cand_c;
  logic             cand_ok;
  logic [31:0]      cand_sum;

  glp_wr_t                wr;
  logic [AW-1:0]          waddr;
  logic [HEIGHT_BITS-1:0] h_wdata;
  logic [LW:0]            l_wdata;
  logic [AW-1:0]          raddr;
  logic [HEIGHT_BITS-1:0] h_rdata;
  logic [LW:0]            l_rdata;
  logic                   l_known;
  logic [LW-1:0]          l_len;
  logic                   lower;
  logic                   do_push;
  logic                   finish;

  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [SW-1:0]   st_wdata;
  logic [AW-1:0]   st_raddr;
  logic [SW-1:0]   st_rdata;

  logic [HEIGHT_W+HEIGHT_BITS-1:0] height_ext;
  logic [LW+RESULT_W-1:0]          best_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_W'(64);
      grid_cols <= CFG_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROWS: grid_rows <= wr_data;
        REG_COLS: grid_cols <= wr_data;
        default:  grid_rows <= grid_rows;
      endcase
    end
  end

  // clamp the grid size to the supported range
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = RSZ'(1);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RSZ'(MAX_ROWS);
    end else begin
      rows_eff = RSZ'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = CSZ'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_eff = CSZ'(MAX_COLS);
    end else begin
      cols_eff = CSZ'(grid_cols);
    end
  end

  assign total     = CNW'(32'(rows_eff) * 32'(cols_eff));
  assign pos_inc   = pos + CNW'(1);
  assign last_cell = (pos_inc >= total);
  assign accept    = cells.valid && cells.ready;
  assign cells.ready = (state == S_LOAD) && !(last_cell && result.valid);

  // height masked to the stored width
  assign height_ext = {{HEIGHT_BITS{1'b0}}, cells.height};

  assign l_known = l_rdata[LW];
  assign l_len   = l_rdata[LW-1:0];
  assign lower   = (ht > h_rdata);
  assign do_push = lower && !l_known && (sp < CNW'(CELLS));
  assign finish  = (s_cnt + CNW'(1)) >= total;

  // neighbour of the top node in the current direction
  always_comb begin
    cand_ok  = 1'b0;
    cand_sum = 32'(top_t);
    cand_r   = top_r;
    cand_c   = top_c;
    unique case (step[1:0])
      DIR_UP: begin
        cand_ok  = (top_r != '0);
        cand_sum = 32'(top_t) - 32'(cols_eff);
        cand_r   = RB'(32'(top_r) - 32'd1);
      end
      DIR_DOWN: begin
        cand_ok  = (32'(top_r) + 32'd1) < 32'(rows_eff);
        cand_sum = 32'(top_t) + 32'(cols_eff);
        cand_r   = RB'(32'(top_r) + 32'd1);
      end
      DIR_LEFT: begin
        cand_ok  = (top_c != '0);
        cand_sum = 32'(top_t) - 32'd1;
        cand_c   = CB'(32'(top_c) - 32'd1);
      end
      DIR_RIGHT: begin
        cand_ok  = (32'(top_c) + 32'd1) < 32'(cols_eff);
        cand_sum = 32'(top_t) + 32'd1;
        cand_c   = CB'(32'(top_c) + 32'd1);
      end
      default: cand_ok = 1'b0;
    endcase
    cand_t = cand_sum[AW-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    wr         = '0;
    waddr      = top_t;
    h_wdata    = height_ext[HEIGHT_BITS-1:0];
    l_wdata    = {1'b1, acc};
    raddr      = top_t;
    st_we      = 1'b0;
    st_waddr   = AW'(sp - CNW'(1));
    st_wdata   = {top_t, top_r, top_c, step + 3'd1};
    st_raddr   = AW'(sp - CNW'(2));
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          wr.h_we = 1'b1;
          wr.l_we = 1'b1;
          waddr   = pos[AW-1:0];
          l_wdata = '0;
          if (last_cell) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        raddr      = s_cnt[AW-1:0];
        state_next = S_ROOT;
      end
      S_ROOT: begin
        raddr = s_cnt[AW-1:0];
        if (l_known) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_HT;
        end
      end
      S_HT: begin
        state_next = S_DIR;
      end
      S_DIR: begin
        raddr = cand_t;
        if (cand_ok) begin
          state_next = S_NB;
        end else if (step == STEP_LAST) begin
          state_next = S_WRITE;
        end
      end
      S_NB: begin
        if (!step[2]) begin
          st_we      = do_push;
          state_next = S_DIR;
        end else if (step == STEP_LAST) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_DIR;
        end
      end
      S_WRITE: begin
        wr.l_we = 1'b1;
        if (sp == CNW'(1)) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        raddr      = st_rdata[SW-1 -: AW];
        state_next = S_HT;
      end
      S_NEXT: begin
        if (finish) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_CHECK;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // load position and stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sp  <= '0;
    end else begin
      if (accept) begin
        pos <= last_cell ? '0 : pos_inc;
      end
      if (state == S_ROOT && !l_known) begin
        sp <= CNW'(1);
      end else if (state == S_NB && !step[2] && do_push) begin
        sp <= sp + CNW'(1);
      end else if (state == S_WRITE) begin
        sp <= sp - CNW'(1);
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (accept && last_cell) begin
          s_cnt <= '0;
          sr    <= '0;
          sc    <= '0;
          best  <= '0;
        end
      end
      S_ROOT: begin
        if (l_known) begin
          if (l_len > best) begin
            best <= l_len;
          end
        end else begin
          top_t <= s_cnt[AW-1:0];
          top_r <= sr;
          top_c <= sc;
          step  <= STEP_FIRST;
        end
      end
      S_HT: begin
        ht  <= h_rdata;
        acc <= LW'(1);
      end
      S_DIR: begin
        if (cand_ok) begin
          nb_t <= cand_t;
          nb_r <= cand_r;
          nb_c <= cand_c;
        end else if (step != STEP_LAST) begin
          step <= step + 3'd1;
        end
      end
      S_NB: begin
        if (!step[2]) begin
          if (do_push) begin
            top_t <= nb_t;
            top_r <= nb_r;
            top_c <= nb_c;
            step  <= STEP_FIRST;
            ht    <= h_rdata;
            acc   <= LW'(1);
          end else begin
            step <= step + 3'd1;
          end
        end else begin
          if (lower && l_known && (l_len + LW'(1)) > acc) begin
            acc <= l_len + LW'(1);
          end
          if (step != STEP_LAST) begin
            step <= step + 3'd1;
          end
        end
      end
      S_WRITE: begin
        if (sp == CNW'(1) && acc > best) begin
          best <= acc;
        end
      end
      S_POP: begin
        {top_t, top_r, top_c, step} <= st_rdata;
      end
      S_NEXT: begin
        if (!finish) begin
          s_cnt <= s_cnt + CNW'(1);
          if ((32'(sc) + 32'd1) >= 32'(cols_eff)) begin
            sc <= '0;
            sr <= RB'(32'(sr) + 32'd1);
          end else begin
            sc <= CB'(32'(sc) + 32'd1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  assign best_ext = {{RESULT_W{1'b0}}, best};

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_NEXT && finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_NEXT && finish) begin
      result.longest_path <= best_ext[RESULT_W-1:0];
    end
  end

  glp_cell_store #(
    .CELLS (CELLS),
    .AW    (AW),
    .HB    (HEIGHT_BITS),
    .LW    (LW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .waddr   (waddr),
    .h_wdata (h_wdata),
    .l_wdata (l_wdata),
    .raddr   (raddr),
    .h_rdata (h_rdata),
    .l_rdata (l_rdata)
  );

  glp_walk_stack #(
    .DEPTH (CELLS),
    .AW    (AW),
    .W     (SW)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

`ifndef SYNTHESIS
  // the walk never runs with an empty stack
  a_stack_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIR || state == S_NB || state == S_WRITE) |-> (sp != '0))
    else $error("walk step with empty stack");

  // a result appears only as a walk completes
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_NEXT))
    else $error("result raised outside walk completion");

  // load position stays inside the height memory
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (pos < CNW'(CELLS)))
    else $error("load position out of range");
`endif

endmodule
`default_nettype wire
